### sv/crz_pkg.sv
// ----------------------------------------------------------------------------
// crz_pkg
// Shared types and constants of the circle rasterizer: field widths, command
// and register codes, reset values and the job word passed from front to back.
// ----------------------------------------------------------------------------
package crz_pkg;

  localparam int XY_W    = 12;
  localparam int RAD_W   = 11;
  localparam int ORG_W   = 11;
  localparam int PIX_W   = 14;
  localparam int DEC_W   = 18;
  localparam int COLOR_W = 24;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] START_LAST_IDX = IDX_W'(4);
  localparam logic [IDX_W-1:0] ADV_LAST_IDX   = IDX_W'(7);

  localparam logic [ORG_W-1:0]   ORIGIN_X_RST   = ORG_W'(320);
  localparam logic [ORG_W-1:0]   ORIGIN_Y_RST   = ORG_W'(240);
  localparam logic [COLOR_W-1:0] DRAW_COLOR_RST = 24'hFFFFFF;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } crz_op_t;

  typedef enum logic {
    RULE_BRESENHAM = 1'b0,
    RULE_MIDPOINT  = 1'b1
  } crz_rule_t;

  typedef enum logic [1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_DRAW_COLOR = 2'd2
  } crz_reg_t;

  typedef struct packed {
    logic                    start;
    logic                    done;
    logic signed [PIX_W-1:0] sx;
    logic signed [PIX_W-1:0] sy;
    logic signed [XY_W-1:0]  px;
    logic signed [XY_W-1:0]  py;
  } crz_job_t;

endpackage

### sv/crz_if.sv
// ----------------------------------------------------------------------------
// crz_cmd_if / crz_pix_if
// Valid/ready channels of the rasterizer: command words in, pixel words out.
// ----------------------------------------------------------------------------
interface crz_cmd_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [crz_pkg::RAD_W-1:0]    radius;
  logic                         algorithm;

  modport source (output valid, opcode, center_x, center_y, radius, algorithm,
                  input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius, algorithm,
                  output ready);
endinterface

interface crz_pix_if;
  logic                             valid;
  logic                             ready;
  logic signed [crz_pkg::PIX_W-1:0] pixel_x;
  logic signed [crz_pkg::PIX_W-1:0] pixel_y;
  logic [crz_pkg::COLOR_W-1:0]      pixel_color;
  logic                             last;
  logic                             done_res;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, done_res,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, done_res,
                  output ready);
endinterface

### sv/crz_front.sv
// ----------------------------------------------------------------------------
// crz_front
// Command front end: latch a circle on start, take one octant step on advance
// and push a job word describing the pixels to emit.
// ----------------------------------------------------------------------------
module crz_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  crz_cmd_if.sink                    cmd,
  input  logic [crz_pkg::ORG_W-1:0]  origin_x,
  input  logic [crz_pkg::ORG_W-1:0]  origin_y,
  input  logic                       q_full,
  output logic                       push,
  output crz_pkg::crz_job_t          job
);

  localparam int PW = crz_pkg::PIX_W;
  localparam int XW = crz_pkg::XY_W;
  localparam int DW = crz_pkg::DEC_W;
  localparam int SW = ((COORD_BITS > PW) ? COORD_BITS : PW) + 1;

  logic signed [XW-1:0] step_x;
  logic signed [XW-1:0] step_y;
  logic signed [DW-1:0] decision;
  logic signed [PW-1:0] screen_center_x;
  logic signed [PW-1:0] screen_center_y;
  logic                 rule_select;
  logic                 active;

  logic                 fire;
  logic                 is_start;
  logic signed [SW-1:0] cx_ext, cy_ext, ox_ext, oy_ext;
  logic signed [PW-1:0] scx_start, scy_start;
  logic signed [DW-1:0] rad_d, dec_start;
  logic                 neg;
  logic signed [XW-1:0] x_next, y_next;
  logic signed [DW-1:0] xd, yd, xnd, ynd, dec_next;
  logic                 done;

  assign fire     = cmd.valid && cmd.ready;
  assign is_start = (cmd.opcode == crz_pkg::OP_START);
  assign cmd.ready = !q_full;

  always_comb begin
    cx_ext    = {{(SW-COORD_BITS){cmd.center_x[COORD_BITS-1]}}, cmd.center_x};
    cy_ext    = {{(SW-COORD_BITS){cmd.center_y[COORD_BITS-1]}}, cmd.center_y};
    ox_ext    = {{(SW-crz_pkg::ORG_W){1'b0}}, origin_x};
    oy_ext    = {{(SW-crz_pkg::ORG_W){1'b0}}, origin_y};
    scx_start = PW'(ox_ext + cx_ext);
    scy_start = PW'(oy_ext - cy_ext);
    rad_d     = {{(DW-crz_pkg::RAD_W){1'b0}}, cmd.radius};
    if (cmd.algorithm == crz_pkg::RULE_MIDPOINT) begin
      dec_start = DW'(1) - rad_d;
    end else begin
      dec_start = DW'(3) - (rad_d <<< 1);
    end
  end

  always_comb begin
    neg    = decision[DW-1];
    x_next = step_x + XW'(1);
    y_next = neg ? step_y : step_y - XW'(1);
    xd     = {{(DW-XW){step_x[XW-1]}}, step_x};
    yd     = {{(DW-XW){step_y[XW-1]}}, step_y};
    xnd    = {{(DW-XW){x_next[XW-1]}}, x_next};
    ynd    = {{(DW-XW){y_next[XW-1]}}, y_next};
    if (rule_select == crz_pkg::RULE_MIDPOINT) begin
      if (neg) begin
        dec_next = decision + (xnd <<< 1) + DW'(1);
      end else begin
        dec_next = decision + ((xnd - ynd) <<< 1) + DW'(1);
      end
    end else begin
      if (neg) begin
        dec_next = decision + (xd <<< 2) + DW'(6);
      end else begin
        dec_next = decision + ((xd - yd) <<< 2) + DW'(10);
      end
    end
    done = (x_next > y_next);
  end

  always_comb begin
    push = fire && (is_start || active);
    if (is_start) begin
      job.start = 1'b1;
      job.done  = 1'b0;
      job.sx    = scx_start;
      job.sy    = scy_start;
      job.px    = '0;
      job.py    = {{(XW-crz_pkg::RAD_W){1'b0}}, cmd.radius};
    end else begin
      job.start = 1'b0;
      job.done  = done;
      job.sx    = screen_center_x;
      job.sy    = screen_center_y;
      job.px    = x_next;
      job.py    = y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x          <= '0;
      step_y          <= '0;
      decision        <= '0;
      screen_center_x <= '0;
      screen_center_y <= '0;
      rule_select     <= 1'b0;
      active          <= 1'b0;
    end else if (fire) begin
      if (is_start) begin
        step_x          <= '0;
        step_y          <= {{(XW-crz_pkg::RAD_W){1'b0}}, cmd.radius};
        decision        <= dec_start;
        screen_center_x <= scx_start;
        screen_center_y <= scy_start;
        rule_select     <= cmd.algorithm;
        active          <= 1'b1;
      end else if (active) begin
        step_x   <= x_next;
        step_y   <= y_next;
        decision <= dec_next;
        if (done) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

### sv/crz_queue.sv
// ----------------------------------------------------------------------------
// crz_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module crz_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  crz_pkg::crz_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output crz_pkg::crz_job_t head
);

  localparam int DEPTH = crz_pkg::QUEUE_DEPTH;
  localparam int PTR_W = crz_pkg::QPTR_W;
  localparam int CNT_W = crz_pkg::QCNT_W;

  crz_pkg::crz_job_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### sv/crz_back.sv
// ----------------------------------------------------------------------------
// crz_back
// Pixel back end: walk the head job through the mirror pattern one pixel
// per cycle while the sink is ready; hold each word in the output register.
// ----------------------------------------------------------------------------
module crz_back (
  input  logic                        clk,
  input  logic                        rst,
  input  crz_pkg::crz_job_t           head,
  input  logic                        empty,
  input  logic [crz_pkg::COLOR_W-1:0] draw_color,
  output logic                        pop,
  crz_pix_if.source                   pix
);

  localparam int PW = crz_pkg::PIX_W;
  localparam int XW = crz_pkg::XY_W;
  localparam int IW = crz_pkg::IDX_W;

  logic [IW-1:0]                 idx;
  logic                          out_valid;
  logic signed [PW-1:0]          out_x;
  logic signed [PW-1:0]          out_y;
  logic [crz_pkg::COLOR_W-1:0]   out_color;
  logic                          out_last;
  logic                          out_done;

  logic                 load;
  logic                 at_last;
  logic signed [PW-1:0] xe, ye, u, v;

  assign load    = !empty && (!out_valid || pix.ready);
  assign at_last = (idx == (head.start ? crz_pkg::START_LAST_IDX
                                        : crz_pkg::ADV_LAST_IDX));
  assign pop     = load && at_last;

  always_comb begin
    xe = {{(PW-XW){head.px[XW-1]}}, head.px};
    ye = {{(PW-XW){head.py[XW-1]}}, head.py};
    u  = '0;
    v  = '0;
    unique case ({head.start, idx})
      {1'b1, 3'd0}: begin u = '0;  v = '0;  end
      {1'b1, 3'd1}: begin u = '0;  v = -ye; end
      {1'b1, 3'd2}: begin u = '0;  v = ye;  end
      {1'b1, 3'd3}: begin u = ye;  v = '0;  end
      {1'b1, 3'd4}: begin u = -ye; v = '0;  end
      {1'b0, 3'd0}: begin u = xe;  v = -ye; end
      {1'b0, 3'd1}: begin u = ye;  v = -xe; end
      {1'b0, 3'd2}: begin u = xe;  v = ye;  end
      {1'b0, 3'd3}: begin u = ye;  v = xe;  end
      {1'b0, 3'd4}: begin u = -xe; v = -ye; end
      {1'b0, 3'd5}: begin u = -ye; v = -xe; end
      {1'b0, 3'd6}: begin u = -xe; v = ye;  end
      {1'b0, 3'd7}: begin u = -ye; v = xe;  end
      default:      begin u = '0;  v = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      idx       <= at_last ? '0 : idx + IW'(1);
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x     <= head.sx + u;
      out_y     <= head.sy + v;
      out_color <= draw_color;
      out_last  <= at_last;
      out_done  <= head.done;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_x     = out_x;
  assign pix.pixel_y     = out_y;
  assign pix.pixel_color = out_color;
  assign pix.last        = out_last;
  assign pix.done_res    = out_done;

endmodule

### sv/circle_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_rasterizer
// Circle rasterizer with Bresenham or midpoint rule, one octant step per
// advance, eight mirrored pixels per step, APB register port.
// Path: a taken command's job word is registered in the job queue, and each
// pixel word in the single output register. Output: one pixel word per cycle
// while the sink is ready, eight words per advance and five per start; a
// four-deep job queue lets commands run ahead. An advance while idle is
// taken and yields no word. Reset: synchronous, clears the queue and circle
// state, loads register defaults.
// ----------------------------------------------------------------------------
module circle_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  crz_cmd_if.sink                     cmd,
  crz_pix_if.source                   pix,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crz_pkg::ADDR_W-1:0]  paddr,
  input  logic [crz_pkg::DATA_W-1:0]  pwdata,
  output logic [crz_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [crz_pkg::ORG_W-1:0]   origin_x;
  logic [crz_pkg::ORG_W-1:0]   origin_y;
  logic [crz_pkg::COLOR_W-1:0] draw_color;

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  crz_pkg::crz_job_t push_job;
  crz_pkg::crz_job_t head;
  logic              cfg_wr;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= crz_pkg::ORIGIN_X_RST;
      origin_y   <= crz_pkg::ORIGIN_Y_RST;
      draw_color <= crz_pkg::DRAW_COLOR_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        crz_pkg::REG_ORIGIN_X:   origin_x   <= pwdata[crz_pkg::ORG_W-1:0];
        crz_pkg::REG_ORIGIN_Y:   origin_y   <= pwdata[crz_pkg::ORG_W-1:0];
        crz_pkg::REG_DRAW_COLOR: draw_color <= pwdata[crz_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      crz_pkg::REG_ORIGIN_X:   prdata = crz_pkg::DATA_W'(origin_x);
      crz_pkg::REG_ORIGIN_Y:   prdata = crz_pkg::DATA_W'(origin_y);
      crz_pkg::REG_DRAW_COLOR: prdata = crz_pkg::DATA_W'(draw_color);
      default:                 prdata = '0;
    endcase
  end

  crz_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  crz_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  crz_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .draw_color (draw_color),
    .pop        (pop),
    .pix        (pix)
  );

endmodule

### sv/crz_checker.sv
// ----------------------------------------------------------------------------
// crz_checker
// Port-level checks on the pixel channel of the circle rasterizer.
// ----------------------------------------------------------------------------
module crz_checker (
  input logic clk,
  input logic rst,
  input logic pix_valid,
  input logic pix_ready,
  input logic pix_last,
  input logic pix_done
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !pix_valid)
    else $error("pixel word valid straight after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid)
    else $error("pixel word dropped while stalled");

  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && !pix_last |=> pix_valid)
    else $error("gap inside a pixel run");

  a_done_steady: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && !pix_last |=> pix_done == $past(pix_done))
    else $error("done flag changed inside a pixel run");

endmodule

bind circle_rasterizer crz_checker u_crz_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pix_last  (pix.last),
  .pix_done  (pix.done_res)
);

### tb/crz_pixel_checker.sv
// ----------------------------------------------------------------------------
// crz_pixel_checker
// Watches the command, pixel and register channels of the circle rasterizer.
// Tracks the register file from observed writes, traces every accepted
// command through its own octant stepper and compares each pixel word,
// field by field, with the oldest word still due.
// ----------------------------------------------------------------------------
module crz_pixel_checker (
  input  logic                       clk,
  input  logic                       rst,
  crz_cmd_if                         cmd,
  crz_pix_if                         pix,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [crz_pkg::ADDR_W-1:0] paddr,
  input  logic [crz_pkg::DATA_W-1:0] pwdata,
  output int                         mismatches,
  output int                         words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [crz_pkg::PIX_W-1:0] x;
    logic signed [crz_pkg::PIX_W-1:0] y;
    logic [crz_pkg::COLOR_W-1:0]      color;
    logic                             last;
    logic                             done;
  } pixel_word_t;

  logic [crz_pkg::ORG_W-1:0]        origin_x;
  logic [crz_pkg::ORG_W-1:0]        origin_y;
  logic [crz_pkg::COLOR_W-1:0]      color;
  logic signed [crz_pkg::XY_W-1:0]  step_x;
  logic signed [crz_pkg::XY_W-1:0]  step_y;
  logic signed [crz_pkg::DEC_W-1:0] decision;
  logic signed [crz_pkg::PIX_W-1:0] centre_x;
  logic signed [crz_pkg::PIX_W-1:0] centre_y;
  crz_pkg::crz_rule_t               rule;
  logic                             active;

  pixel_word_t pixels_due[$];
  int          fail_count;
  int          word_count;

  initial begin
    mismatches = 0;
    words_due  = 0;
    fail_count = 0;
    word_count = 0;
  end

  function automatic void plot(int x, int y, logic last, logic done);
    pixel_word_t w;
    w.x     = crz_pkg::PIX_W'(x);
    w.y     = crz_pkg::PIX_W'(y);
    w.color = color;
    w.last  = last;
    w.done  = done;
    pixels_due.push_back(w);
  endfunction

  task automatic trace_command(crz_pkg::crz_op_t op, int cx, int cy, int r,
                               crz_pkg::crz_rule_t alg);
    int   sx;
    int   sy;
    int   x;
    int   y;
    logic done;
    if (op == crz_pkg::OP_START) begin
      rule     = alg;
      centre_x = crz_pkg::PIX_W'(int'(origin_x) + cx);
      centre_y = crz_pkg::PIX_W'(int'(origin_y) - cy);
      step_x   = '0;
      step_y   = crz_pkg::XY_W'(r);
      decision = (alg == crz_pkg::RULE_MIDPOINT) ? crz_pkg::DEC_W'(1 - r)
                                                 : crz_pkg::DEC_W'(3 - 2 * r);
      active   = 1'b1;
      sx = int'(centre_x);
      sy = int'(centre_y);
      plot(sx, sy, 1'b0, 1'b0);
      plot(sx, sy - r, 1'b0, 1'b0);
      plot(sx, sy + r, 1'b0, 1'b0);
      plot(sx + r, sy, 1'b0, 1'b0);
      plot(sx - r, sy, 1'b1, 1'b0);
    end else if (active) begin
      if (rule == crz_pkg::RULE_BRESENHAM) begin
        // old x and y feed the update
        if (decision < 0) begin
          decision = crz_pkg::DEC_W'(decision + 4 * step_x + 6);
          step_x   = crz_pkg::XY_W'(step_x + 1);
        end else begin
          decision = crz_pkg::DEC_W'(decision + 4 * (step_x - step_y) + 10);
          step_x   = crz_pkg::XY_W'(step_x + 1);
          step_y   = crz_pkg::XY_W'(step_y - 1);
        end
      end else begin
        // new x and y feed the update
        if (decision < 0) begin
          step_x   = crz_pkg::XY_W'(step_x + 1);
          decision = crz_pkg::DEC_W'(decision + 2 * step_x + 1);
        end else begin
          step_x   = crz_pkg::XY_W'(step_x + 1);
          step_y   = crz_pkg::XY_W'(step_y - 1);
          decision = crz_pkg::DEC_W'(decision + 2 * (step_x - step_y) + 1);
        end
      end
      x    = int'(step_x);
      y    = int'(step_y);
      sx   = int'(centre_x);
      sy   = int'(centre_y);
      done = (x > y);
      plot(sx + x, sy - y, 1'b0, done);
      plot(sx + y, sy - x, 1'b0, done);
      plot(sx + x, sy + y, 1'b0, done);
      plot(sx + y, sy + x, 1'b0, done);
      plot(sx - x, sy - y, 1'b0, done);
      plot(sx - y, sy - x, 1'b0, done);
      plot(sx - x, sy + y, 1'b0, done);
      plot(sx - y, sy + x, 1'b1, done);
      if (done) active = 1'b0;
    end
  endtask

  function automatic void note_failure();
    fail_count++;
  endfunction

  always @(posedge clk) begin : watch
    pixel_word_t want;
    if (rst) begin
      origin_x = crz_pkg::ORIGIN_X_RST;
      origin_y = crz_pkg::ORIGIN_Y_RST;
      color    = crz_pkg::DRAW_COLOR_RST;
      step_x   = '0;
      step_y   = '0;
      decision = '0;
      centre_x = '0;
      centre_y = '0;
      rule     = crz_pkg::RULE_BRESENHAM;
      active   = 1'b0;
      pixels_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (crz_pkg::crz_reg_t'(paddr[crz_pkg::ADDR_W-1:2]))
          crz_pkg::REG_ORIGIN_X:   origin_x = pwdata[crz_pkg::ORG_W-1:0];
          crz_pkg::REG_ORIGIN_Y:   origin_y = pwdata[crz_pkg::ORG_W-1:0];
          crz_pkg::REG_DRAW_COLOR: color    = pwdata[crz_pkg::COLOR_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        word_count++;
        if (pixels_due.size() == 0) begin
          note_failure();
          if (fail_count <= 10)
            $display("pixel word %0d: none due, got x=%0d y=%0d colour=%06h",
                     word_count, pix.pixel_x, pix.pixel_y, pix.pixel_color);
        end else begin
          want = pixels_due.pop_front();
          if (want.x !== pix.pixel_x || want.y !== pix.pixel_y ||
              want.color !== pix.pixel_color || want.last !== pix.last ||
              want.done !== pix.done_res) begin
            note_failure();
            if (fail_count <= 10)
              $display({"pixel word %0d: expected x=%0d y=%0d colour=%06h last=%0b ",
                        "done=%0b, got x=%0d y=%0d colour=%06h last=%0b done=%0b"},
                       word_count, want.x, want.y, want.color, want.last, want.done,
                       pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last,
                       pix.done_res);
          end
        end
      end
      if (cmd.valid && cmd.ready)
        trace_command(crz_pkg::crz_op_t'(cmd.opcode), int'(cmd.center_x),
                      int'(cmd.center_y), int'(cmd.radius),
                      crz_pkg::crz_rule_t'(cmd.algorithm));
    end
    mismatches <= fail_count;
    words_due  <= pixels_due.size();
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Top of the circle rasterizer test: clock, reset, command and register
// stimulus, a stalling pixel sink and the verdict. A directed run of degenerate,
// small and extreme circles is followed by random circle traces under several
// register settings; the checker beside the block predicts every pixel word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_PAUSE = 16;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [crz_pkg::ADDR_W-1:0] paddr;
  logic [crz_pkg::DATA_W-1:0] pwdata;
  logic [crz_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  int                         mismatches;
  int                         words_due;
  int                         items_sent;
  bit                         send_burst;

  crz_cmd_if #(.COORD_BITS(crz_pkg::XY_W)) cmd_ch ();
  crz_pix_if                               pix_ch ();

  circle_rasterizer #(.COORD_BITS(crz_pkg::XY_W)) uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .pix     (pix_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  crz_pixel_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .pix        (pix_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [crz_pkg::XY_W-1:0] rand_coord();
    return crz_pkg::XY_W'($urandom_range(0, (1 << crz_pkg::XY_W) - 1));
  endfunction

  function automatic crz_pkg::crz_rule_t rand_rule();
    return crz_pkg::crz_rule_t'($urandom_range(0, 1));
  endfunction

  task automatic send_word(crz_pkg::crz_op_t op, logic signed [crz_pkg::XY_W-1:0] cx,
                           logic signed [crz_pkg::XY_W-1:0] cy,
                           logic [crz_pkg::RAD_W-1:0] r, crz_pkg::crz_rule_t alg);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : int'($urandom_range(0, 18));
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.opcode    <= op;
    cmd_ch.center_x  <= cx;
    cmd_ch.center_y  <= cy;
    cmd_ch.radius    <= r;
    cmd_ch.algorithm <= alg;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic advance();
    send_word(crz_pkg::OP_ADVANCE, rand_coord(), rand_coord(),
              crz_pkg::RAD_W'($urandom_range(0, 2047)), rand_rule());
  endtask

  task automatic draw_circle(logic signed [crz_pkg::XY_W-1:0] cx,
                             logic signed [crz_pkg::XY_W-1:0] cy,
                             logic [crz_pkg::RAD_W-1:0] r, crz_pkg::crz_rule_t alg,
                             int steps);
    send_word(crz_pkg::OP_START, cx, cy, r, alg);
    repeat (steps) advance();
  endtask

  // enough steps to close the octant, the spare ones land on an idle block
  task automatic full_circle(logic signed [crz_pkg::XY_W-1:0] cx,
                             logic signed [crz_pkg::XY_W-1:0] cy,
                             logic [crz_pkg::RAD_W-1:0] r, crz_pkg::crz_rule_t alg);
    draw_circle(cx, cy, r, alg, int'(r) * 3 / 4 + 2);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic set_registers(logic [crz_pkg::ORG_W-1:0] ox,
                               logic [crz_pkg::ORG_W-1:0] oy,
                               logic [crz_pkg::COLOR_W-1:0] colour);
    crz_pkg::crz_reg_t          idx [3];
    logic [crz_pkg::DATA_W-1:0] value [3];
    idx[0] = crz_pkg::REG_ORIGIN_X;   value[0] = crz_pkg::DATA_W'(ox);
    idx[1] = crz_pkg::REG_ORIGIN_Y;   value[1] = crz_pkg::DATA_W'(oy);
    idx[2] = crz_pkg::REG_DRAW_COLOR; value[2] = crz_pkg::DATA_W'(colour);
    for (int i = 0; i < 3; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[i], 2'b00};
      pwdata  <= value[i];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(int budget);
    int stop;
    stop = items_sent + budget;
    // a circle left open carries its old centre into the new setting
    advance();
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6:
          full_circle(rand_coord(), rand_coord(), crz_pkg::RAD_W'($urandom_range(0, 24)),
                      rand_rule());
        7:
          draw_circle(rand_coord(), rand_coord(),
                      crz_pkg::RAD_W'($urandom_range(0, 2047)), rand_rule(),
                      int'($urandom_range(0, 6)));
        8:
          advance();
        default:
          draw_circle(rand_coord(), rand_coord(), crz_pkg::RAD_W'($urandom_range(0, 63)),
                      rand_rule(), int'($urandom_range(1, 12)));
      endcase
    end
  endtask

  initial begin : pixel_sink
    int hold;
    int words_taken;
    bit stall_free;
    pix_ch.ready <= 1'b0;
    words_taken = 0;
    stall_free  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) stall_free = !stall_free;
      hold = stall_free ? 0 : int'($urandom_range(0, 18));
      // hold off long enough for the job queue to fill and stall commands
      if (words_taken % 900 == 100) hold = 400;
      if (hold > 0) begin
        pix_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      pix_ch.ready <= 1'b1;
      @(posedge clk);
      while (!pix_ch.valid) @(posedge clk);
      words_taken++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("circle_rasterizer: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.opcode    <= crz_pkg::OP_START;
    cmd_ch.center_x  <= '0;
    cmd_ch.center_y  <= '0;
    cmd_ch.radius    <= '0;
    cmd_ch.algorithm <= crz_pkg::RULE_BRESENHAM;
    items_sent = 0;
    send_burst = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero radius: centre five times, first step closes, next one is idle
    draw_circle(12'sd0, 12'sd0, 11'd0, crz_pkg::RULE_BRESENHAM, 2);
    draw_circle(-12'sd1, 12'sd1, 11'd0, crz_pkg::RULE_MIDPOINT, 1);
    full_circle(12'sd5, -12'sd3, 11'd5, crz_pkg::RULE_BRESENHAM);
    full_circle(-12'sd7, 12'sd9, 11'd7, crz_pkg::RULE_MIDPOINT);
    // extreme centres and radius, second start drops the first circle
    draw_circle(12'sd2047, -12'sd2048, 11'd2047, crz_pkg::RULE_BRESENHAM, 2);
    draw_circle(-12'sd2048, 12'sd2047, 11'd2047, crz_pkg::RULE_MIDPOINT, 2);

    drain();
    set_registers('0, '0, '0);
    random_phase(70);
    drain();
    set_registers('1, '1, '1);
    random_phase(70);
    repeat (3) begin
      drain();
      set_registers(crz_pkg::ORG_W'($urandom_range(0, 2047)),
                    crz_pkg::ORG_W'($urandom_range(0, 2047)),
                    crz_pkg::COLOR_W'($urandom_range(0, 24'hFFFFFF)));
      random_phase(68);
    end
    drain();

    if (mismatches == 0 && words_due == 0) begin
      $display("circle_rasterizer: match");
    end else begin
      $display("circle_rasterizer: mismatch");
    end
    $finish;
  end

endmodule
